>>> rtl/core/cfrt_pkg.sv
package cfrt_pkg;

    localparam int SLOTS      = 64;
    localparam int COUNT_BITS = 16;
    localparam int FRAME_BITS = 48;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ENTRY_BITS = FRAME_BITS + COUNT_BITS;

    localparam logic [SLOT_W-1:0]     SLOT_LAST  = SLOT_W'(SLOTS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] COUNT_INIT = COUNT_BITS'(2);

    typedef enum logic [1:0] {
        REQ_TRACK   = 2'd0,
        REQ_QUERY   = 2'd1,
        REQ_RELEASE = 2'd2
    } req_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] frame;
        logic [COUNT_BITS-1:0] count;
    } entry_t;

endpackage

>>> rtl/core/cfrt_if.sv
interface cfrt_req_if;
    import cfrt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            req_type;
    logic [FRAME_BITS-1:0] frame_addr;

    modport source (output valid, output req_type, output frame_addr, input ready);
    modport sink (input valid, input req_type, input frame_addr, output ready);
endinterface

interface cfrt_rsp_if;
    logic valid;
    logic ready;
    logic answer;

    modport source (output valid, output answer, input ready);
    modport sink (input valid, input answer, output ready);
endinterface

>>> rtl/core/cow_frame_refcount_table_top.sv
// sequence: after a request is accepted the scan reads each slot in turn, followed by the
//   last compare, the write-back and the load of the output register
// one request at a time: the next request is taken only back in the idle state, once the
//   response is loaded; the scan is serial over the single read port of the slot memory
// a finished response may wait in the output register while the next request is taken
// reset: rst_n asynchronous, active low; clears all valid marks, the fsm and the output
//   register; frame and count memory contents are left undefined
module cow_frame_refcount_table_top
    import cfrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cfrt_req_if.sink    req,
    cfrt_rsp_if.source  rsp
);

    // frame address and count of each slot share one memory word
    entry_t mem [SLOTS];

    // valid marks live in flops so reset clears them at once
    logic [SLOTS-1:0] valid_reg;

    state_t state_reg, state_next;

    // captured request
    logic [1:0]            req_type_reg;
    logic [FRAME_BITS-1:0] frame_reg;

    // scan pointer issues one read per cycle; compare runs in the cycle after the read
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] cmp_idx_reg;
    logic              rd_pend_reg;
    entry_t            rd_data_reg;

    // scan results
    logic                  hit_reg;
    logic [SLOT_W-1:0]     hit_idx_reg;
    logic [COUNT_BITS-1:0] hit_count_reg;
    logic                  free_reg;
    logic [SLOT_W-1:0]     free_idx_reg;

    logic answer_reg;
    logic out_valid_reg;
    logic out_answer_reg;

    // decoded control
    logic                  accept;
    logic                  issue_rd;
    logic                  cmp_valid;
    logic                  cmp_match;
    logic                  mem_we;
    logic [SLOT_W-1:0]     mem_waddr;
    entry_t                mem_wdata;
    logic                  valid_set;
    logic                  valid_clr;
    logic                  answer_next;
    logic                  out_load;

    assign accept     = req.valid && req.ready;
    assign cmp_valid  = valid_reg[cmp_idx_reg];
    assign cmp_match  = cmp_valid && (rd_data_reg.frame == frame_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == SLOT_LAST)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the fsm and the write-back decision
    always_comb
    begin
        req.ready   = 1'b0;
        issue_rd    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = hit_idx_reg;
        mem_wdata   = '{frame: frame_reg, count: hit_count_reg};
        valid_set   = 1'b0;
        valid_clr   = 1'b0;
        answer_next = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_SCAN:
            begin
                issue_rd = 1'b1;
            end
            ST_UPDATE:
            begin
                case (req_type_reg)
                    REQ_TRACK:
                    begin
                        if (hit_reg)
                        begin
                            // saturating increment of a present frame
                            mem_we = 1'b1;
                            if (hit_count_reg != COUNT_MAX)
                            begin
                                mem_wdata.count = hit_count_reg + COUNT_ONE;
                            end
                            answer_next = 1'b1;
                        end
                        else if (free_reg)
                        begin
                            // lowest free slot takes the new shared frame
                            mem_we          = 1'b1;
                            mem_waddr       = free_idx_reg;
                            mem_wdata.count = COUNT_INIT;
                            valid_set       = 1'b1;
                            answer_next     = 1'b1;
                        end
                    end
                    REQ_QUERY:
                    begin
                        answer_next = hit_reg;
                    end
                    REQ_RELEASE:
                    begin
                        if (!hit_reg)
                        begin
                            answer_next = 1'b1;
                        end
                        else if (hit_count_reg <= COUNT_ONE)
                        begin
                            valid_clr   = 1'b1;
                            answer_next = 1'b1;
                        end
                        else
                        begin
                            mem_we          = 1'b1;
                            mem_wdata.count = hit_count_reg - COUNT_ONE;
                        end
                    end
                    default:
                    begin
                        answer_next = 1'b0;
                    end
                endcase
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // slot memory: one read and one write port, read data registered
    always_ff @(posedge clk)
    begin
        if (issue_rd)
        begin
            rd_data_reg <= mem[idx_reg];
        end
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= issue_rd;

            if (accept)
            begin
                idx_reg  <= '0;
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            else if (issue_rd && idx_reg != SLOT_LAST)
            begin
                idx_reg <= idx_reg + SLOT_W'(1);
            end

            // first matching valid slot and lowest free slot, found in one pass
            if (rd_pend_reg)
            begin
                if (cmp_match && !hit_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (!cmp_valid && !free_reg)
                begin
                    free_reg <= 1'b1;
                end
            end

            if (valid_set)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (valid_clr)
            begin
                valid_reg[hit_idx_reg] <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg <= req.req_type;
            frame_reg    <= req.frame_addr;
        end
        if (issue_rd)
        begin
            cmp_idx_reg <= idx_reg;
        end
        if (rd_pend_reg && cmp_match && !hit_reg)
        begin
            hit_idx_reg   <= cmp_idx_reg;
            hit_count_reg <= rd_data_reg.count;
        end
        if (rd_pend_reg && !cmp_valid && !free_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
        if (state_reg == ST_UPDATE)
        begin
            answer_reg <= answer_next;
        end
        if (out_load)
        begin
            out_answer_reg <= answer_reg;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.answer = out_answer_reg;

endmodule

>>> rtl/core/cfrt_checker.sv
module cfrt_checker
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic rsp_answer
);

    logic       req_acc;
    logic       rsp_acc;
    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (req_acc && !rsp_acc)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (rsp_acc && !req_acc)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    // requests accepted whose response is not yet taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // a response always belongs to an outstanding request
    a_rsp_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 2'd0)
        else $error("response without outstanding request");

    // at most one request in the scan plus one waiting response
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("too many outstanding transactions");

    // one request at a time: no acceptance right after an acceptance
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> !req_ready)
        else $error("request taken during a scan");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_answer))
        else $error("stalled response changed");

endmodule

bind cow_frame_refcount_table_top cfrt_checker u_cfrt_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_answer (rsp.answer)
);

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import cfrt_pkg::*;

    // request code with no meaning to the block: must change nothing and answer 0
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // operation mixes for the random chunks
    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_HOT   = 2;

    // receiver stall patterns
    localparam int RX_OPEN   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;

    localparam int POOL_SIZE    = 96;
    localparam int HOT_SIZE     = 6;
    localparam int RANDOM_ITEMS = 1280;
    localparam int HOLD_CYCLES  = 600;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PRINT_LIMIT  = 50;

    typedef struct {
        logic [1:0]            kind;
        logic [FRAME_BITS-1:0] frame;
        bit                    drain;
    } req_item_t;

    typedef struct {
        logic                  answer;
        logic [1:0]            kind;
        logic [FRAME_BITS-1:0] frame;
    } answer_item_t;

    logic clk;
    logic rst_n;

    cfrt_req_if req_bus ();
    cfrt_rsp_if rsp_bus ();

    cow_frame_refcount_table_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // shadow copy of the frame table
    logic                  shadow_valid [SLOTS];
    logic [FRAME_BITS-1:0] shadow_frame [SLOTS];
    logic [COUNT_BITS-1:0] shadow_count [SLOTS];

    req_item_t    pending_q[$];
    answer_item_t answer_q[$];

    logic [FRAME_BITS-1:0] pool_frame [POOL_SIZE];

    int  err_count   = 0;
    int  rsp_count   = 0;
    int  idle_cycles = 0;
    bit  req_taken   = 1'b0;

    // sender burst/gap state
    int  gap_left    = 0;
    int  burst_left  = 1;

    // receiver state
    int  hold_left   = 0;
    int  hold_mark   = 300;
    int  rx_mode     = RX_OPEN;
    int  rx_left     = 50;
    int  rx_phase    = 0;

    // applies one request to the shadow table and returns the expected answer
    function automatic logic refcount_apply(input logic [1:0] kind,
                                            input logic [FRAME_BITS-1:0] frame);
        int   hit;
        int   vacant;
        logic ans;
        hit    = -1;
        vacant = -1;
        ans    = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (shadow_valid[i])
            begin
                if (hit < 0 && shadow_frame[i] == frame)
                    hit = i;
            end
            else if (vacant < 0)
            begin
                vacant = i;
            end
        end
        case (kind)
            REQ_TRACK:
            begin
                if (hit >= 0)
                begin
                    // saturating increment
                    if (shadow_count[hit] != COUNT_MAX)
                        shadow_count[hit] = shadow_count[hit] + COUNT_ONE;
                    ans = 1'b1;
                end
                else if (vacant >= 0)
                begin
                    shadow_valid[vacant] = 1'b1;
                    shadow_frame[vacant] = frame;
                    shadow_count[vacant] = COUNT_INIT;
                    ans = 1'b1;
                end
                else
                begin
                    // table full
                    ans = 1'b0;
                end
            end
            REQ_QUERY:
            begin
                ans = (hit >= 0);
            end
            REQ_RELEASE:
            begin
                if (hit < 0)
                begin
                    // never shared, owner may free it
                    ans = 1'b1;
                end
                else if (shadow_count[hit] <= COUNT_ONE)
                begin
                    shadow_valid[hit] = 1'b0;
                    shadow_count[hit] = '0;
                    ans = 1'b1;
                end
                else
                begin
                    shadow_count[hit] = shadow_count[hit] - COUNT_ONE;
                    ans = 1'b0;
                end
            end
            default:
            begin
                ans = 1'b0;
            end
        endcase
        return ans;
    endfunction

    task automatic add_req(input logic [1:0] kind, input logic [FRAME_BITS-1:0] frame,
                           input bit drain);
        req_item_t item;
        item.kind  = kind;
        item.frame = frame;
        item.drain = drain;
        pending_q.push_back(item);
    endtask

    function automatic logic [FRAME_BITS-1:0] random_frame();
        return FRAME_BITS'({$urandom, $urandom});
    endfunction

    // free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // every input known from time zero
    initial
    begin
        req_bus.valid      = 1'b0;
        req_bus.req_type   = REQ_TRACK;
        req_bus.frame_addr = '0;
        rsp_bus.ready      = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_frame[i] = '0;
            shadow_count[i] = '0;
        end
    end

    // request driver: pops the pending queue in bursts with random gaps,
    // holds a transaction until it is accepted, and waits for the table to
    // go quiet before any item flagged as a drain point
    always @(negedge clk)
    begin : driver
        req_item_t nxt;
        logic      next_valid;
        int        g;
        if (rst_n && !(req_bus.valid && !req_taken))
        begin
            next_valid = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (pending_q.size() != 0 && !(pending_q[0].drain && answer_q.size() != 0))
            begin
                nxt = pending_q.pop_front();
                req_bus.req_type   <= nxt.kind;
                req_bus.frame_addr <= nxt.frame;
                next_valid = 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    // new burst length and the gap that follows it
                    burst_left = $urandom_range(1, 12);
                    g = $urandom_range(0, 99);
                    if (g < 25)
                        gap_left = 0;
                    else if (g < 65)
                        gap_left = $urandom_range(1, 8);
                    else
                        gap_left = $urandom_range(9, 100);
                end
            end
            req_bus.valid <= next_valid;
        end
    end

    // response receiver: switches among stall patterns, and twice holds off
    // for a long stretch so the output register and the request side back up
    always @(negedge clk)
    begin : receiver
        logic ready_n;
        ready_n = 1'b0;
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
            end
            else if (rsp_count >= hold_mark && hold_mark < 1100)
            begin
                hold_left = HOLD_CYCLES;
                hold_mark = hold_mark + 700;
            end
            else
            begin
                case (rx_mode)
                    RX_OPEN:   ready_n = 1'b1;
                    RX_COIN:   ready_n = 1'($urandom_range(0, 1));
                    RX_SPARSE: ready_n = (rx_phase % 5 == 0);
                    default:   ready_n = 1'b1;
                endcase
                rx_phase++;
                rx_left--;
                if (rx_left <= 0)
                begin
                    rx_mode  = $urandom_range(RX_OPEN, RX_SPARSE);
                    rx_left  = $urandom_range(20, 400);
                    rx_phase = 0;
                end
            end
        end
        rsp_bus.ready <= ready_n;
    end

    // monitor: predicts on every accepted request, checks every accepted
    // response against the oldest expectation, and runs the watchdog
    always @(posedge clk)
    begin : monitor
        answer_item_t exp_item;
        bit           moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (req_bus.valid && req_bus.ready)
            begin
                exp_item.kind   = req_bus.req_type;
                exp_item.frame  = req_bus.frame_addr;
                exp_item.answer = refcount_apply(req_bus.req_type, req_bus.frame_addr);
                answer_q.push_back(exp_item);
                moved = 1'b1;
            end
            req_taken <= req_bus.valid && req_bus.ready;
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                rsp_count++;
                moved = 1'b1;
                if (answer_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= PRINT_LIMIT)
                        $display("%0t: response with nothing expected, expected none, got %0b",
                                 $realtime, rsp_bus.answer);
                end
                else
                begin
                    exp_item = answer_q.pop_front();
                    if (rsp_bus.answer !== exp_item.answer)
                    begin
                        err_count++;
                        if (err_count <= PRINT_LIMIT)
                            $display("%0t: answer for req %0d frame %h: expected %0b, got %0b",
                                     $realtime, exp_item.kind, exp_item.frame,
                                     exp_item.answer, rsp_bus.answer);
                    end
                end
            end
            // watchdog on cycles with no transaction on either side
            if (moved)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial
    begin : stimulus
        logic [FRAME_BITS-1:0] ones;
        logic [FRAME_BITS-1:0] alt_a;
        logic [FRAME_BITS-1:0] alt_b;
        logic [FRAME_BITS-1:0] addr;
        logic [1:0]            op;
        int                    made;
        int                    chunk;
        int                    mix;
        int                    len;
        int                    hot_base;
        int                    r;

        ones  = '1;
        alt_a = {(FRAME_BITS/2){2'b10}};
        alt_b = {(FRAME_BITS/2){2'b01}};

        // frame pool: extremes, every single-bit address, then random frames
        pool_frame[0] = '0;
        pool_frame[1] = ones;
        for (int i = 0; i < FRAME_BITS; i++)
            pool_frame[2 + i] = FRAME_BITS'(1) << i;
        for (int i = 2 + FRAME_BITS; i < POOL_SIZE; i++)
            pool_frame[i] = random_frame();

        // directed: absent frames, insert, hit, count down to free, slot reuse
        add_req(REQ_QUERY,   '0,    1'b0);  // absent
        add_req(REQ_RELEASE, '0,    1'b0);  // release of a frame never shared
        add_req(REQ_TRACK,   '0,    1'b0);  // new entry with count 2
        add_req(REQ_TRACK,   ones,  1'b0);
        add_req(REQ_QUERY,   ones,  1'b0);
        add_req(REQ_QUERY,   ones >> 1, 1'b0);  // one bit away from a stored frame
        add_req(REQ_TRACK,   '0,    1'b0);  // hit, count 3
        add_req(REQ_RELEASE, '0,    1'b0);  // count 2
        add_req(REQ_RELEASE, '0,    1'b0);  // count 1
        add_req(REQ_RELEASE, '0,    1'b0);  // freed
        add_req(REQ_QUERY,   '0,    1'b0);
        add_req(REQ_TRACK,   alt_a, 1'b0);  // takes the lowest freed slot
        add_req(REQ_TRACK,   alt_b, 1'b0);
        add_req(REQ_RELEASE, ones,  1'b0);
        add_req(REQ_RELEASE, ones,  1'b0);  // freed
        add_req(REQ_QUERY,   ones,  1'b0);
        add_req(REQ_UNUSED,  alt_a, 1'b0);  // unused code, table untouched
        add_req(REQ_UNUSED,  ones,  1'b0);
        add_req(REQ_QUERY,   alt_a, 1'b0);
        add_req(REQ_RELEASE, alt_b, 1'b0);
        add_req(REQ_RELEASE, alt_b, 1'b0);
        add_req(REQ_RELEASE, alt_a, 1'b1);  // sender pauses until all answers are in
        add_req(REQ_RELEASE, alt_a, 1'b0);

        // random chunks: fill pushes toward a full table, drain frees
        // entries, hot works a handful of frames hard
        made  = 0;
        chunk = 0;
        while (made < RANDOM_ITEMS)
        begin
            if (chunk < 2)
            begin
                mix = MIX_FILL;
            end
            else
            begin
                r = $urandom_range(0, 99);
                mix = (r < 40) ? MIX_FILL : (r < 75) ? MIX_DRAIN : MIX_HOT;
            end
            len      = (chunk < 2) ? 100 : $urandom_range(40, 100);
            hot_base = $urandom_range(0, POOL_SIZE - HOT_SIZE);
            for (int j = 0; j < len; j++)
            begin
                r = $urandom_range(0, 99);
                case (mix)
                    MIX_FILL:  op = (r < 75) ? REQ_TRACK : (r < 88) ? REQ_QUERY : REQ_RELEASE;
                    MIX_DRAIN: op = (r < 15) ? REQ_TRACK : (r < 35) ? REQ_QUERY : REQ_RELEASE;
                    default:   op = (r < 40) ? REQ_TRACK : (r < 60) ? REQ_QUERY : REQ_RELEASE;
                endcase
                // occasional noise: unused code or a frame from outside the pool
                if ($urandom_range(0, 49) == 0)
                    op = REQ_UNUSED;
                if ($urandom_range(0, 19) == 0)
                    addr = random_frame();
                else if (mix == MIX_HOT)
                    addr = pool_frame[hot_base + $urandom_range(0, HOT_SIZE - 1)];
                else
                    addr = pool_frame[$urandom_range(0, POOL_SIZE - 1)];
                add_req(op, addr, (j == 0) && (chunk % 3 == 2));
                if (op != REQ_UNUSED)
                    made++;
            end
            chunk++;
        end

        // reset held low, then released at a falling edge
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for all stimulus to go out and every answer to come back
        while (pending_q.size() != 0 || answer_q.size() != 0 || req_bus.valid)
            @(posedge clk);
        // give any stray response time to show up
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
